// ===== src/dlsq_pkg.sv =====
// package for the delta list sleep queue
// holds sizes, result kinds and the sequencer state type; no dependencies
`timescale 1ns / 1ps

package dlsq_pkg;

  // queue geometry
  localparam int CAPACITY   = 16;
  localparam int TICK_WIDTH = 16;
  localparam int MAX_WAKE   = 16;
  localparam int THREAD_W   = 8;
  localparam int SLEEP_W    = 16;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int WAKE_W = (MAX_WAKE > 1) ? $clog2(MAX_WAKE) : 1;

  // compare width for clamping the requested sleep
  localparam int CMP_W = (TICK_WIDTH > SLEEP_W) ? TICK_WIDTH : SLEEP_W;
  localparam logic [CMP_W-1:0] TICK_MAX_EXT = {CMP_W{1'b1}} >> (CMP_W - TICK_WIDTH);

  // input actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_WOKEN    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_RESP,
    ST_TICK_RD,
    ST_TICK_DEC,
    ST_SHR_RD,
    ST_SHR_WR,
    ST_WAKE_EMIT
  } state_t;

endpackage

// ===== src/delta_list_sleep_queue.sv =====
// delta list sleep queue: slot store, one read port, one write port and a sequencer
// depends on dlsq_pkg
//
// channel  direction  ports                                   handshake
// in       input      in_action, in_thread_id, in_sleep_ticks in_valid / in_ready
// out      output     out_kind, out_woken_id, out_last        out_valid / out_ready
//
// one request at a time; the slot store has a single registered read port, so each
// slot visited takes a read state and then a compare or write state. an insert walks
// past the slots that expire no later, shifts the later slots up one and places the
// new thread; a rejected insert or a tick on an empty queue goes straight to the result.
// a tick decrements a nonzero head and, for each thread woken, moves every later slot
// down one. the sequencer returns to idle before the next request is taken. reset clears
// the state and control registers, occupancy included; slot contents stay undefined
// until written. results leave through an output register, so a stalled out_ready holds
// the sequencer only when a new result is due.
`timescale 1ns / 1ps

module delta_list_sleep_queue
  import dlsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [THREAD_W-1:0]   in_thread_id,
  input  logic [SLEEP_W-1:0]    in_sleep_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [THREAD_W-1:0]   out_woken_id,
  output logic                  out_last
);

  // slot store
  logic [THREAD_W-1:0]   slot_thread [CAPACITY];
  logic [TICK_WIDTH-1:0] slot_delta  [CAPACITY];

  // control registers
  state_t            state_r, state_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [OCC_W-1:0]  pos_r, pos_nxt;
  logic [OCC_W-1:0]  idx_r, idx_nxt;
  logic [WAKE_W-1:0] wake_cnt_r, wake_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [TICK_WIDTH-1:0] wait_r, wait_nxt;
  logic [THREAD_W-1:0]   tid_r, tid_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [THREAD_W-1:0]   wake_id_r, wake_id_nxt;
  logic [TICK_WIDTH-1:0] head_delta_r, head_delta_nxt;
  logic [THREAD_W-1:0]   head_thread_r, head_thread_nxt;
  kind_t                 out_kind_r, out_kind_nxt;
  logic [THREAD_W-1:0]   out_woken_id_r, out_woken_id_nxt;
  logic                  out_last_r, out_last_nxt;

  // store ports
  logic [IDX_W-1:0]      raddr;
  logic [THREAD_W-1:0]   rd_thread_r;
  logic [TICK_WIDTH-1:0] rd_delta_r;
  logic [IDX_W-1:0]      waddr;
  logic                  we_thread, we_delta;
  logic [THREAD_W-1:0]   wthread;
  logic [TICK_WIDTH-1:0] wdelta;

  // helpers
  logic                  in_acc;
  logic                  out_free;
  logic [OCC_W-1:0]      idx_m1;
  logic [OCC_W-1:0]      pos_p1;
  logic [CMP_W-1:0]      sleep_ext;
  logic [CMP_W-1:0]      sleep_sat;
  logic                  more_due;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign idx_m1       = idx_r - OCC_W'(1);
  assign pos_p1       = pos_r + OCC_W'(1);
  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_woken_id = out_woken_id_r;
  assign out_last     = out_last_r;

  // clamp the requested sleep into 1 .. tick maximum
  always_comb begin
    sleep_ext = CMP_W'(in_sleep_ticks);
    sleep_sat = sleep_ext;
    if (sleep_ext == '0) begin
      sleep_sat = CMP_W'(1);
    end else if (sleep_ext > TICK_MAX_EXT) begin
      sleep_sat = TICK_MAX_EXT;
    end
  end

  // another thread due after the current wake, within the per-tick wake limit
  assign more_due = (occ_r != '0) && (head_delta_r == '0) &&
                    (wake_cnt_r < WAKE_W'(MAX_WAKE - 1));

  // slot store read and write
  always_ff @(posedge clk) begin
    rd_thread_r <= slot_thread[raddr];
    rd_delta_r  <= slot_delta[raddr];
    if (we_thread) begin
      slot_thread[waddr] <= wthread;
    end
    if (we_delta) begin
      slot_delta[waddr] <= wdelta;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      wake_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      wake_cnt_r  <= wake_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wait_r         <= wait_nxt;
    tid_r          <= tid_nxt;
    kind_r         <= kind_nxt;
    wake_id_r      <= wake_id_nxt;
    head_delta_r   <= head_delta_nxt;
    head_thread_r  <= head_thread_nxt;
    out_kind_r     <= out_kind_nxt;
    out_woken_id_r <= out_woken_id_nxt;
    out_last_r     <= out_last_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    occ_nxt          = occ_r;
    pos_nxt          = pos_r;
    idx_nxt          = idx_r;
    wake_cnt_nxt     = wake_cnt_r;
    wait_nxt         = wait_r;
    tid_nxt          = tid_r;
    kind_nxt         = kind_r;
    wake_id_nxt      = wake_id_r;
    head_delta_nxt   = head_delta_r;
    head_thread_nxt  = head_thread_r;
    out_valid_nxt    = out_ready ? 1'b0 : out_valid_r;
    out_kind_nxt     = out_kind_r;
    out_woken_id_nxt = out_woken_id_r;
    out_last_nxt     = out_last_r;
    raddr            = '0;
    waddr            = '0;
    we_thread        = 1'b0;
    we_delta         = 1'b0;
    wthread          = tid_r;
    wdelta           = wait_r;

    case (state_r)
      // take a request
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_INSERT) begin
            tid_nxt  = in_thread_id;
            wait_nxt = sleep_sat[TICK_WIDTH-1:0];
            pos_nxt  = '0;
            if (occ_r == OCC_W'(CAPACITY)) begin
              kind_nxt  = KIND_FULL;
              state_nxt = ST_RESP;
            end else begin
              state_nxt = ST_SCAN_RD;
            end
          end else if (occ_r == '0) begin
            kind_nxt  = KIND_NONE;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_TICK_RD;
          end
        end
      end

      // insert: walk past slots that expire no later
      ST_SCAN_RD: begin
        raddr = pos_r[IDX_W-1:0];
        if (pos_r == occ_r) begin
          idx_nxt   = occ_r;
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (rd_delta_r <= wait_r) begin
          wait_nxt  = wait_r - rd_delta_r;
          pos_nxt   = pos_p1;
          state_nxt = ST_SCAN_RD;
        end else begin
          idx_nxt   = occ_r;
          state_nxt = ST_SHIFT_RD;
        end
      end

      // insert: open a gap at the insert position, top slot first
      ST_SHIFT_RD: begin
        raddr = idx_m1[IDX_W-1:0];
        if (idx_r == pos_r) begin
          state_nxt = ST_PLACE;
        end else begin
          state_nxt = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        waddr     = idx_r[IDX_W-1:0];
        we_thread = 1'b1;
        we_delta  = 1'b1;
        wthread   = rd_thread_r;
        // the successor loses the new thread's residual wait
        wdelta    = (idx_r == pos_p1) ? (rd_delta_r - wait_r) : rd_delta_r;
        idx_nxt   = idx_m1;
        state_nxt = ST_SHIFT_RD;
      end

      ST_PLACE: begin
        waddr     = pos_r[IDX_W-1:0];
        we_thread = 1'b1;
        we_delta  = 1'b1;
        occ_nxt   = occ_r + OCC_W'(1);
        kind_nxt  = KIND_INSERTED;
        state_nxt = ST_RESP;
      end

      // single result, always the last
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = kind_r;
          out_woken_id_nxt = '0;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      // tick: fetch the head
      ST_TICK_RD: begin
        raddr     = '0;
        state_nxt = ST_TICK_DEC;
      end

      ST_TICK_DEC: begin
        waddr       = '0;
        wake_id_nxt = rd_thread_r;
        wake_cnt_nxt = '0;
        idx_nxt     = OCC_W'(1);
        if (rd_delta_r == '0) begin
          state_nxt = ST_SHR_RD;
        end else begin
          we_delta = 1'b1;
          wdelta   = rd_delta_r - TICK_WIDTH'(1);
          if (rd_delta_r == TICK_WIDTH'(1)) begin
            state_nxt = ST_SHR_RD;
          end else begin
            kind_nxt  = KIND_NONE;
            state_nxt = ST_RESP;
          end
        end
      end

      // tick: drop the head, moving every slot down one
      ST_SHR_RD: begin
        raddr = idx_r[IDX_W-1:0];
        if (idx_r == occ_r) begin
          occ_nxt   = occ_r - OCC_W'(1);
          state_nxt = ST_WAKE_EMIT;
        end else begin
          state_nxt = ST_SHR_WR;
        end
      end

      ST_SHR_WR: begin
        waddr     = idx_m1[IDX_W-1:0];
        we_thread = 1'b1;
        we_delta  = 1'b1;
        wthread   = rd_thread_r;
        wdelta    = rd_delta_r;
        // the first slot moved is the new head
        if (idx_r == OCC_W'(1)) begin
          head_delta_nxt  = rd_delta_r;
          head_thread_nxt = rd_thread_r;
        end
        idx_nxt   = idx_r + OCC_W'(1);
        state_nxt = ST_SHR_RD;
      end

      // tick: report the woken thread once the next head is known
      ST_WAKE_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = KIND_WOKEN;
          out_woken_id_nxt = wake_id_r;
          out_last_nxt     = !more_due;
          if (more_due) begin
            wake_id_nxt  = head_thread_r;
            wake_cnt_nxt = wake_cnt_r + WAKE_W'(1);
            idx_nxt      = OCC_W'(1);
            state_nxt    = ST_SHR_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // occupancy never exceeds the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  // placing a thread grows the queue by one
  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE) |=> (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("insert did not grow occupancy");

  // the scan only compares occupied slots
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CMP) |-> (pos_r < occ_r))
    else $error("scan beyond occupancy");

  // the gap shift never moves a slot below the insert position
  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_WR) |-> (idx_r > pos_r))
    else $error("shift below insert position");

  // an insert into a full queue is rejected
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_INSERT) && (occ_r == OCC_W'(CAPACITY)))
      |=> ((state_r == ST_RESP) && (kind_r == KIND_FULL)))
    else $error("full queue did not reject insert");
`endif

endmodule

// ===== sim/delta_list_sleep_queue_tb.sv =====
`timescale 1ns / 1ps
// testbench for delta_list_sleep_queue: sleep and tick requests checked against a local
// delta list predictor, with random flow control on both channels; needs dlsq_pkg and the rtl

module delta_list_sleep_queue_tb
  import dlsq_pkg::*;
();

  typedef struct packed {
    logic                action;
    logic [THREAD_W-1:0] tid;
    logic [SLEEP_W-1:0]  ticks;
    logic [2:0]          gap_max;
  } sleep_req_t;

  typedef struct packed {
    kind_t               kind;
    logic [THREAD_W-1:0] tid;
    logic                last;
  } wake_result_t;

  // known levels on every input from time zero
  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                in_action      = ACT_INSERT;
  logic [THREAD_W-1:0] in_thread_id   = '0;
  logic [SLEEP_W-1:0]  in_sleep_ticks = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [1:0]          out_kind;
  logic [THREAD_W-1:0] out_woken_id;
  logic                out_last;

  // requests still to be offered and results still owed by the block
  sleep_req_t   reqs_pending[$];
  wake_result_t results_owed[$];

  // predicted sleep queue
  logic [THREAD_W-1:0]   slot_tid [CAPACITY];
  logic [TICK_WIDTH-1:0] slot_dlt [CAPACITY];
  int unsigned           slots_used = 0;

  int unsigned reqs_accepted = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  logic        req_taken     = 1'b0;
  logic        res_taken     = 1'b0;
  logic        hold_off      = 1'b0;
  int unsigned send_gap      = 0;
  int unsigned recv_wait     = 0;

  delta_list_sleep_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_thread_id   (in_thread_id),
    .in_sleep_ticks (in_sleep_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_woken_id   (out_woken_id),
    .out_last       (out_last)
  );

  function automatic void owe(kind_t kind, logic [THREAD_W-1:0] tid, logic last);
    wake_result_t r;
    r.kind = kind;
    r.tid  = tid;
    r.last = last;
    results_owed.push_back(r);
  endfunction

  // advance the predicted queue by one request and record the results it owes
  function automatic void sleep_queue_step(logic action, logic [THREAD_W-1:0] tid,
                                           logic [SLEEP_W-1:0] ticks);
    logic [CMP_W-1:0]    rem;
    int unsigned         pos;
    int unsigned         woke;
    logic [THREAD_W-1:0] head_tid;
    logic                more;
    if (action == ACT_INSERT) begin
      if (slots_used >= CAPACITY) begin
        owe(KIND_FULL, '0, 1'b1);
      end else begin
        // zero sleep counts as one tick, oversize sleep saturates
        rem = CMP_W'(ticks);
        if (rem == '0) rem = CMP_W'(1);
        if (rem > TICK_MAX_EXT) rem = TICK_MAX_EXT;
        // walk past every slot due no later than the new one
        pos = 0;
        while (pos < slots_used && CMP_W'(slot_dlt[pos]) <= rem) begin
          rem = rem - CMP_W'(slot_dlt[pos]);
          pos++;
        end
        for (int i = slots_used; i > pos; i--) begin
          slot_tid[i] = slot_tid[i-1];
          slot_dlt[i] = slot_dlt[i-1];
        end
        slot_tid[pos] = tid;
        slot_dlt[pos] = rem[TICK_WIDTH-1:0];
        slots_used++;
        // successor keeps only what is left after the new slot
        if (pos + 1 < slots_used)
          slot_dlt[pos+1] = slot_dlt[pos+1] - rem[TICK_WIDTH-1:0];
        owe(KIND_INSERTED, '0, 1'b1);
      end
    end else begin
      woke = 0;
      // a head already at zero is left over from a capped tick and is not decremented
      if (slots_used > 0 && slot_dlt[0] != '0) slot_dlt[0] = slot_dlt[0] - TICK_WIDTH'(1);
      more = (slots_used > 0 && slot_dlt[0] == '0);
      while (more) begin
        head_tid = slot_tid[0];
        for (int i = 1; i < slots_used; i++) begin
          slot_tid[i-1] = slot_tid[i];
          slot_dlt[i-1] = slot_dlt[i];
        end
        slots_used--;
        woke++;
        more = (slots_used > 0 && slot_dlt[0] == '0 && woke < MAX_WAKE);
        owe(KIND_WOKEN, head_tid, !more);
      end
      if (woke == 0) owe(KIND_NONE, '0, 1'b1);
    end
  endfunction

  function automatic void add_sleep(logic [THREAD_W-1:0] tid, logic [SLEEP_W-1:0] ticks,
                                    int unsigned gap_max);
    sleep_req_t r;
    r.action  = ACT_INSERT;
    r.tid     = tid;
    r.ticks   = ticks;
    r.gap_max = 3'(gap_max);
    reqs_pending.push_back(r);
  endfunction

  // payload fields are ignored on a tick, so they carry noise
  function automatic void add_tick(int unsigned gap_max);
    sleep_req_t r;
    r.action  = ACT_TICK;
    r.tid     = THREAD_W'($urandom);
    r.ticks   = SLEEP_W'($urandom);
    r.gap_max = 3'(gap_max);
    reqs_pending.push_back(r);
  endfunction

  // clock
  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request driver, fed from the pending queue
  always @(negedge clk) begin : driver
    sleep_req_t nxt;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (reqs_pending.size() != 0) begin
        nxt = reqs_pending.pop_front();
        in_valid       <= 1'b1;
        in_action      <= nxt.action;
        in_thread_id   <= nxt.tid;
        in_sleep_ticks <= nxt.ticks;
        send_gap = $urandom_range(0, nxt.gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall after each result, busy and quiet stretches alternate
  always @(negedge clk) begin : receiver
    int unsigned stall_max;
    stall_max = ((results_seen / 48) % 2 == 0) ? 4 : 0;
    if (rst_n) begin
      if (res_taken) recv_wait = $urandom_range(0, stall_max);
      out_ready <= !(hold_off || recv_wait != 0);
      if (!hold_off && recv_wait != 0) recv_wait--;
    end
  end

  // long receiver hold-off while requests keep coming, so the block backs up
  initial begin : pressure
    wait (reqs_accepted >= 60);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (300) @(negedge clk);
    hold_off <= 1'b0;
  end

  // scoreboard: check accepted results, then predict accepted requests
  always @(posedge clk) begin : scoreboard
    wake_result_t want;
    if (rst_n) begin
      req_taken <= in_valid && in_ready;
      res_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d id %02h last %0d",
                     out_kind, out_woken_id, out_last);
        end else begin
          want = results_owed.pop_front();
          if (out_kind !== want.kind || out_woken_id !== want.tid || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want kind %0d id %02h last %0d, got kind %0d id %02h last %0d",
                       want.kind, want.tid, want.last, out_kind, out_woken_id, out_last);
          end
        end
      end
      if (in_valid && in_ready) begin
        reqs_accepted++;
        sleep_queue_step(in_action, in_thread_id, in_sleep_ticks);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int unsigned        tick_pct;
    int unsigned        gap_max;
    int unsigned        pick;
    logic [SLEEP_W-1:0] ticks;

    // zero sleep, equal wake times, middle insert cutting its successor
    add_sleep(8'h00, 16'd0, 0);
    add_sleep(8'hFF, 16'd1, 4);
    add_sleep(8'h5A, 16'd4, 0);
    add_sleep(8'hA5, 16'd2, 2);
    add_tick(0);
    add_tick(4);
    // insert at the head, then drain to an empty queue and tick it
    add_sleep(8'h3C, 16'd1, 0);
    add_tick(0);
    add_tick(0);
    add_tick(3);
    // longest sleep stays put; the tick after it finds nobody due
    add_sleep(8'h77, 16'hFFFF, 0);
    add_tick(0);
    // fill the queue, offer one more, then wake a crowd in one tick
    for (int k = 0; k < CAPACITY - 1; k++) add_sleep(THREAD_W'(8'h11 * (k + 1)), 16'd2, 0);
    add_sleep(8'h80, 16'h8000, 1);
    add_tick(0);
    add_tick(0);

    // random batches: tick share and sender gaps vary per batch
    for (int b = 0; b < 10; b++) begin
      tick_pct = 20 + 20 * $urandom_range(0, 2);
      gap_max  = (b % 3 == 1) ? 0 : 4;
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 99) < tick_pct) begin
          add_tick(gap_max);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 4) ticks = SLEEP_W'($urandom_range(0, (1 << SLEEP_W) - 1));
          else if (pick < 10) ticks = '0;
          else if (pick < 80) ticks = SLEEP_W'($urandom_range(1, 6));
          else ticks = SLEEP_W'($urandom_range(7, 24));
          add_sleep(THREAD_W'($urandom_range(0, (1 << THREAD_W) - 1)), ticks, gap_max);
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request to go in and every owed result to come out
    while (reqs_pending.size() != 0 || in_valid || results_owed.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 40) @(posedge clk);

    if (mismatches == 0 && results_owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
